>>> src/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constants of the streaming SHA-256 hasher: channel payloads,
// controller-to-datapath command and status, round constants, initial hash.
// ----------------------------------------------------------------------------
package shs_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        part_last;
   } rsp_payload_type;

   // source of the byte shifted into the block buffer
   localparam logic [1:0] BYTE_MSG  = 2'd0;
   localparam logic [1:0] BYTE_MARK = 2'd1;
   localparam logic [1:0] BYTE_ZERO = 2'd2;
   localparam logic [1:0] BYTE_LEN  = 2'd3;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;

   typedef struct packed {
      logic       shift_en;
      logic [1:0] byte_sel;
      logic       count_bits;
      logic       work_load;
      logic       round_en;
      logic [5:0] round_idx;
      logic       hash_add;
      logic       finish;
   } shs_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       rsp_busy;
   } shs_sts_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage

>>> src/shs_ctrl.sv
// ----------------------------------------------------------------------------
// shs_ctrl
// Sequencer: takes message bytes, runs padding, counts the 64 compression
// rounds and hands the finished digest to the output register.
// ----------------------------------------------------------------------------
module shs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  shs_pkg::req_payload_type req_payload,
   input  shs_pkg::shs_sts_type    sts,
   output shs_pkg::shs_cmd_type    cmd
);
   import shs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_HADD  = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       pad_ff, pad_in;
   logic       mark_ff, mark_in;
   logic       final_ff, final_in;
   logic       block_full;

   always_comb begin
      state_in   = state_ff;
      rnd_in     = rnd_ff;
      pad_in     = pad_ff;
      mark_in    = mark_ff;
      final_in   = final_ff;
      req_ready  = 1'b0;
      block_full = 1'b0;
      cmd        = '0;
      cmd.byte_sel  = BYTE_MSG;
      cmd.round_idx = rnd_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift_en   = req_payload.has_byte;
               cmd.count_bits = req_payload.has_byte;
               block_full     = req_payload.has_byte && (sts.fill == FILL_LAST);
               if (req_payload.end_of_message) begin
                  pad_in   = 1'b1;
                  mark_in  = 1'b0;
                  final_in = 1'b0;
               end
               if (block_full) begin
                  state_in = S_ROUND;
               end else if (req_payload.end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.shift_en = 1'b1;
            if (!mark_ff) begin
               cmd.byte_sel = BYTE_MARK;
               mark_in      = 1'b1;
               // length fits in this block only if the mark lands before byte 56
               final_in     = sts.fill < LEN_START;
            end else if (final_ff && (sts.fill >= LEN_START)) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
            block_full = sts.fill == FILL_LAST;
            if (block_full) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = S_HADD;
            end
         end
         S_HADD: begin
            cmd.hash_add = 1'b1;
            if (!pad_ff) begin
               state_in = S_IDLE;
            end else if (final_ff) begin
               state_in = S_DONE;
            end else begin
               final_in = 1'b1;
               state_in = S_PAD;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               pad_in     = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (block_full) begin
         cmd.work_load = 1'b1;
         rnd_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rnd_ff   <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         final_ff <= final_in;
      end
   end

`ifndef SYNTHESIS
   a_no_shift_in_round: assert property (@(posedge clock) disable iff (reset)
      !(cmd.round_en && cmd.shift_en))
      else $error("byte shifted into buffer during a compression round");
   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.rsp_busy)
      else $error("digest loaded while previous digest still draining");
   a_last_round_then_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rnd_ff == ROUND_LAST) |=> cmd.hash_add)
      else $error("hash update did not follow the last round");
   a_full_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      cmd.work_load |=> (cmd.round_en && rnd_ff == 6'd0))
      else $error("full block did not start the compression rounds");
`endif

endmodule

>>> src/shs_datapath.sv
// ----------------------------------------------------------------------------
// shs_datapath
// Block buffer doubling as the rolling message schedule, one SHA-256 round
// unit, hash words, bit counter and the digest output register.
// ----------------------------------------------------------------------------
module shs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  shs_pkg::shs_cmd_type     cmd,
   output shs_pkg::shs_sts_type     sts,
   input  logic [7:0]               msg_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output shs_pkg::rsp_payload_type rsp_payload
);
   import shs_pkg::*;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   logic [511:0] buf_ff, buf_in;
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];
   logic [31:0]  hash_ff [8];
   logic [63:0]  bits_ff;
   logic [5:0]   fill_ff;
   logic [255:0] digest_ff;
   logic [1:0]   part_ff;
   logic         rsp_valid_ff;

   logic [7:0]  shift_byte;
   logic [7:0]  len_byte;
   logic [31:0] wt, w1, w9, w14, w_next;
   logic [31:0] s0, s1, big_s0, big_s1, ch, maj, t1, t2;

   // big-endian length byte for buffer positions 56..63
   assign len_byte = 8'(bits_ff >> {~fill_ff[2:0], 3'b000});

   always_comb begin
      case (cmd.byte_sel)
         BYTE_MSG:  shift_byte = msg_byte;
         BYTE_MARK: shift_byte = PAD_MARK;
         BYTE_ZERO: shift_byte = 8'h00;
         BYTE_LEN:  shift_byte = len_byte;
         default:   shift_byte = 8'h00;
      endcase
   end

   // schedule window: word 0 is the current round's word
   assign wt  = buf_ff[511:480];
   assign w1  = buf_ff[479:448];
   assign w9  = buf_ff[223:192];
   assign w14 = buf_ff[63:32];
   assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
   assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
   assign w_next = wt + s0 + w9 + s1;

   assign big_s1 = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
   assign big_s0 = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
   assign ch     = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj    = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                   (work_ff[1] & work_ff[2]);
   assign t1     = work_ff[7] + big_s1 + ch + ROUND_K[cmd.round_idx] + wt;
   assign t2     = big_s0 + maj;

   always_comb begin
      buf_in = buf_ff;
      if (cmd.shift_en) begin
         buf_in = {buf_ff[503:0], shift_byte};
      end else if (cmd.round_en) begin
         buf_in = {buf_ff[479:0], w_next};
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         work_in[i] = work_ff[i];
      end
      if (cmd.work_load) begin
         for (int i = 0; i < 8; i++) begin
            work_in[i] = hash_ff[i];
         end
      end else if (cmd.round_en) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      for (int i = 0; i < 8; i++) begin
         work_ff[i] <= work_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= HASH_INIT[i];
         end
         bits_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
               hash_ff[i] <= HASH_INIT[i];
            end
            bits_ff <= '0;
         end else begin
            if (cmd.hash_add) begin
               for (int i = 0; i < 8; i++) begin
                  hash_ff[i] <= hash_ff[i] + work_ff[i];
               end
            end
            if (cmd.count_bits) begin
               bits_ff <= bits_ff + 64'd8;
            end
         end
         if (cmd.shift_en) begin
            fill_ff <= fill_ff + 6'd1;
         end
      end
   end

   // digest register drains one 64-bit part per beat, top part first
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         digest_ff <= {hash_ff[0], hash_ff[1], hash_ff[2], hash_ff[3],
                       hash_ff[4], hash_ff[5], hash_ff[6], hash_ff[7]};
      end else if (rsp_valid_ff && rsp_ready) begin
         digest_ff <= {digest_ff[191:0], 64'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         part_ff      <= '0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
         part_ff      <= '0;
      end else if (rsp_valid_ff && rsp_ready) begin
         part_ff <= part_ff + 2'd1;
         if (part_ff == 2'd3) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.digest_part = digest_ff[255:192];
   assign rsp_payload.part_index  = part_ff;
   assign rsp_payload.part_last   = part_ff == 2'd3;

   assign sts.fill     = fill_ff;
   assign sts.rsp_busy = rsp_valid_ff;

`ifndef SYNTHESIS
   a_finish_starts_parts: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && part_ff == 2'd0))
      else $error("digest load did not present part zero");
   a_last_part_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && part_ff == 2'd3 && !cmd.finish) |=> !rsp_valid_ff)
      else $error("output still valid after the last digest part");
   a_add_on_empty_buffer: assert property (@(posedge clock) disable iff (reset)
      cmd.hash_add |-> fill_ff == 6'd0)
      else $error("hash update with a partly filled block buffer");
`endif

endmodule

>>> src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: bytes in, 256-bit digest out as four 64-bit parts.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                 | handshake
//  req     | in        | data_byte, has_byte, end_of_message     | req_valid / req_ready
//  rsp     | out       | digest_part, part_index, part_last      | rsp_valid / rsp_ready
//
//  one byte a cycle while a block fills; a full block holds req_ready low
//  through 64 rounds on the single round unit, then the hash update
//  end of message: padding shifts in one byte a cycle, then one or two
//  compressions, then the digest waits for the output register to drain
//  rsp stalls only block the next end of message, not the byte stream
//  reset is synchronous; no clearing pass
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  shs_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output shs_pkg::rsp_payload_type rsp_payload
);
   import shs_pkg::*;

   shs_cmd_type cmd;
   shs_sts_type sts;

   shs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .sts         (sts),
      .cmd         (cmd)
   );

   shs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .msg_byte    (req_payload.data_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
